/* rtl/sparse_table_range_min_defines.svh */
// Assertion macros used by the checker file.
`ifndef SPARSE_TABLE_RANGE_MIN_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define STMIN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, off while reset is asserted.
`define STMIN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define STMIN_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: reset behavior failed");

`endif

/* rtl/stmin_pkg.sv */
package stmin_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int LEVELS_DEF       = 11;

    // Wide enough for any element count or index over the full parameter range.
    localparam int POS_W = 17;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 10;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] SENTINEL = 32'd1000000000;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_RESULT = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_APPEND = 2'd1,
        S_QUERY  = 2'd2,
        S_DONE   = 2'd3
    } t_state;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   start;  // append position or query left index
        logic [POS_W-1:0]   size;   // query length
    } t_op;

endpackage

/* rtl/stmin_front.sv */
module stmin_front #(
    parameter int MAX_ELEMENTS = stmin_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [1:0]                    i_cmd,
    input  logic [stmin_pkg::VALUE_W-1:0] i_value,
    input  logic [stmin_pkg::INDEX_W-1:0] i_left,
    input  logic [stmin_pkg::INDEX_W-1:0] i_right,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output stmin_pkg::t_op                o_op
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int PW = stmin_pkg::POS_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [PW-1:0] w_count_ext;
    logic [PW-1:0] w_left_ext;
    logic [PW-1:0] w_right_ext;

    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;
    assign w_count_ext = PW'(r_count);
    assign w_left_ext  = PW'(i_left);
    assign w_right_ext = PW'(i_right);

    // Track the element count here so every item is classified against the
    // count that all earlier items leave behind.
    always_comb begin
        n_count       = r_count;
        o_op.kind     = stmin_pkg::KIND_RESULT;
        o_op.status   = stmin_pkg::ST_OK;
        o_op.value    = i_value;
        o_op.start    = '0;
        o_op.size     = '0;
        case (i_cmd)
            stmin_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            stmin_pkg::CMD_APPEND: begin
                if (r_count == CW'(MAX_ELEMENTS)) begin
                    o_op.status = stmin_pkg::ST_FULL;
                end else begin
                    o_op.kind  = stmin_pkg::KIND_APPEND;
                    o_op.start = w_count_ext;
                    n_count    = r_count + CW'(1);
                end
            end
            stmin_pkg::CMD_QUERY: begin
                if ((w_left_ext > w_right_ext) || (w_right_ext >= w_count_ext)) begin
                    o_op.status = stmin_pkg::ST_BAD_RANGE;
                end else begin
                    o_op.kind  = stmin_pkg::KIND_QUERY;
                    o_op.start = w_left_ext;
                    o_op.size  = w_right_ext - w_left_ext + PW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

/* rtl/stmin_queue.sv */
module stmin_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stmin_pkg::t_op i_op,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output stmin_pkg::t_op o_head
);

    localparam int DEPTH = stmin_pkg::QUEUE_DEPTH;
    localparam int QW    = $clog2(DEPTH);

    stmin_pkg::t_op r_slots [DEPTH];
    logic [QW-1:0]  r_wr_ptr;
    logic [QW-1:0]  r_rd_ptr;
    logic [QW:0]    r_fill;

    assign o_full  = (r_fill == (QW + 1)'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (QW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (QW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_op;
        end
    end

endmodule

/* rtl/stmin_back.sv */
module stmin_back #(
    parameter int MAX_ELEMENTS = stmin_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = stmin_pkg::LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  stmin_pkg::t_op                i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [stmin_pkg::VALUE_W-1:0] o_minimum,
    output stmin_pkg::t_status            o_status
);

    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int IW    = $clog2(MAX_ELEMENTS);
    localparam int LW    = $clog2(LEVELS);
    localparam int AW    = LW + IW;
    localparam int DEPTH = LEVELS * (2 ** IW);
    localparam int BW    = ((CW > LEVELS) ? CW : LEVELS) + 1;
    localparam int VW    = stmin_pkg::VALUE_W;

    // Table entry (start, level) lives at address {level, start}.
    logic [VW-1:0] r_table [DEPTH];

    stmin_pkg::t_state  r_state;
    stmin_pkg::t_state  n_state;
    logic [CW-1:0]      r_len;
    logic [LW-1:0]      r_lvl;
    logic [BW-1:0]      r_block;
    logic [VW-1:0]      r_cur;
    logic [VW-1:0]      r_best;
    logic [CW-1:0]      r_left;
    logic [CW-1:0]      r_size;
    logic               r_pend;
    logic [VW-1:0]      r_rdata;
    logic [VW-1:0]      r_res_min;
    stmin_pkg::t_status r_res_status;
    logic               r_out_valid;
    logic [VW-1:0]      r_out_min;
    stmin_pkg::t_status r_out_status;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [VW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    logic [CW-1:0] w_len_in;
    logic [CW-1:0] w_len_m2;
    logic [BW-1:0] w_len_ext;
    logic [BW-1:0] w_size_ext;
    logic [BW-1:0] w_block2;
    logic [CW-1:0] w_s_cur;
    logic [CW-1:0] w_s_next;
    logic          w_more;
    logic          w_issue;
    logic          w_out_free;
    logic [VW-1:0] w_cmp_b;
    logic [VW-1:0] w_lo;

    assign w_len_in   = i_head.start[CW-1:0] + CW'(1);
    assign w_len_m2   = w_len_in - CW'(2);
    assign w_len_ext  = BW'(r_len);
    assign w_size_ext = BW'(r_size);
    assign w_block2   = r_block << 1;
    assign w_s_cur    = r_len - r_block[CW-1:0];
    assign w_s_next   = r_len - w_block2[CW-1:0];
    assign w_more     = (r_lvl < LW'(LEVELS - 1)) && (w_block2 <= w_len_ext);
    assign w_issue    = (r_size != '0) && (r_block <= w_size_ext);
    assign w_out_free = !r_out_valid || i_ready;

    // One comparator, shared by the append fill and the query walk.
    assign w_cmp_b = (r_state == stmin_pkg::S_APPEND) ? r_cur : r_best;
    assign w_lo    = (r_rdata < w_cmp_b) ? r_rdata : w_cmp_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            stmin_pkg::S_IDLE: begin
                if (!i_empty) begin
                    case (i_head.kind)
                        stmin_pkg::KIND_APPEND: begin
                            n_state = (w_len_in >= CW'(2)) ? stmin_pkg::S_APPEND
                                                           : stmin_pkg::S_DONE;
                        end
                        stmin_pkg::KIND_QUERY: n_state = stmin_pkg::S_QUERY;
                        default:               n_state = stmin_pkg::S_DONE;
                    endcase
                end
            end
            stmin_pkg::S_APPEND: begin
                n_state = w_more ? stmin_pkg::S_APPEND : stmin_pkg::S_DONE;
            end
            stmin_pkg::S_QUERY: begin
                n_state = (r_size == '0) ? stmin_pkg::S_DONE : stmin_pkg::S_QUERY;
            end
            stmin_pkg::S_DONE: begin
                n_state = w_out_free ? stmin_pkg::S_IDLE : stmin_pkg::S_DONE;
            end
            default: n_state = stmin_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = i_head.value;
        w_re    = 1'b0;
        w_raddr = '0;
        case (r_state)
            stmin_pkg::S_IDLE: begin
                o_pop = !i_empty;
                if (!i_empty && (i_head.kind == stmin_pkg::KIND_APPEND)) begin
                    // Level 0 of the new element, plus the read for level 1.
                    w_we    = 1'b1;
                    w_waddr = {LW'(0), i_head.start[IW-1:0]};
                    w_re    = (w_len_in >= CW'(2));
                    w_raddr = {LW'(0), w_len_m2[IW-1:0]};
                end
            end
            stmin_pkg::S_APPEND: begin
                w_we    = 1'b1;
                w_waddr = {r_lvl, w_s_cur[IW-1:0]};
                w_wdata = w_lo;
                w_re    = w_more;
                w_raddr = {r_lvl, w_s_next[IW-1:0]};
            end
            stmin_pkg::S_QUERY: begin
                w_re    = w_issue;
                w_raddr = {r_lvl, r_left[IW-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_table[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stmin_pkg::S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == stmin_pkg::S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                stmin_pkg::S_IDLE:  r_pend <= 1'b0;
                stmin_pkg::S_QUERY: r_pend <= (r_size != '0) && w_issue;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            stmin_pkg::S_IDLE: begin
                if (!i_empty) begin
                    r_res_min    <= stmin_pkg::SENTINEL;
                    r_res_status <= i_head.status;
                    r_len        <= w_len_in;
                    r_cur        <= i_head.value;
                    r_left       <= i_head.start[CW-1:0];
                    r_size       <= i_head.size[CW-1:0];
                    r_best       <= '1;
                    if (i_head.kind == stmin_pkg::KIND_QUERY) begin
                        r_lvl   <= LW'(LEVELS - 1);
                        r_block <= BW'(1) << (LEVELS - 1);
                    end else begin
                        r_lvl   <= LW'(1);
                        r_block <= BW'(2);
                    end
                end
            end
            stmin_pkg::S_APPEND: begin
                r_cur   <= w_lo;
                r_lvl   <= r_lvl + LW'(1);
                r_block <= w_block2;
            end
            stmin_pkg::S_QUERY: begin
                if (r_pend) begin
                    r_best <= w_lo;
                end
                if (r_size == '0) begin
                    r_res_min <= r_pend ? w_lo : r_best;
                end else if (w_issue) begin
                    r_left <= r_left + r_block[CW-1:0];
                    r_size <= r_size - r_block[CW-1:0];
                end else begin
                    // Block too long for what is left: drop one level.
                    r_lvl   <= r_lvl - LW'(1);
                    r_block <= r_block >> 1;
                end
            end
            stmin_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out_min    <= r_res_min;
                    r_out_status <= r_res_status;
                end
            end
            default: ;
        endcase
    end

    assign o_valid   = r_out_valid;
    assign o_minimum = r_out_min;
    assign o_status  = r_out_status;

endmodule

/* rtl/sparse_table_range_min.sv */
// Channel   Direction  tdata                                  tuser
// s_axis    in         [31:0] value, [41:32] left_index,      [1:0] command
//                      [51:42] right_index, [55:52] zero
// m_axis    out        [31:0] minimum                         [1:0] status
//
// Clear, full append, bad range and unused command go from queue head to result via S_DONE.
// Append: writes level 0, then fills the higher levels in turn while the block fits.
// Query: walks down from the top level, reading each entry whose block fits what is left;
// both walks go through the single read port of the table memory.
// Reset zeroes the element count, the queue and the back-end state; the table holds no state until written.
// A two-entry queue keeps s_axis taking transactions, until it fills, while the back end works
// or while a result waits in the output register.
module sparse_table_range_min #(
    parameter int MAX_ELEMENTS = stmin_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = stmin_pkg::LEVELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // value, left_index, right_index, zero pad (low to high)
    input  logic [stmin_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // minimum
    output logic [stmin_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]                      m_axis_tuser
);

    localparam int VW = stmin_pkg::VALUE_W;
    localparam int XW = stmin_pkg::INDEX_W;

    stmin_pkg::t_op     w_op;
    stmin_pkg::t_op     w_head;
    stmin_pkg::t_status w_status;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;

    stmin_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .i_cmd  (s_axis_tuser),
        .i_value(s_axis_tdata[VW-1:0]),
        .i_left (s_axis_tdata[VW+XW-1:VW]),
        .i_right(s_axis_tdata[VW+2*XW-1:VW+XW]),
        .i_full (w_full),
        .o_ready(s_axis_tready),
        .o_push (w_push),
        .o_op   (w_op)
    );

    stmin_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_op   (w_op),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_empty(w_empty),
        .o_head (w_head)
    );

    stmin_back #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .LEVELS      (LEVELS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_minimum(m_axis_tdata),
        .o_status (w_status)
    );

    assign m_axis_tuser = w_status;

endmodule

/* rtl/stmin_checker.sv */
`include "sparse_table_range_min_defines.svh"

module stmin_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [stmin_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);

    // A stalled result holds.
    `STMIN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Only the three defined status codes ever appear.
    `STMIN_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tuser == stmin_pkg::ST_OK) || (m_axis_tuser == stmin_pkg::ST_BAD_RANGE) ||
        (m_axis_tuser == stmin_pkg::ST_FULL))

    // Every error carries the sentinel.
    `STMIN_ASSERT_IMP(a_error_sentinel, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != stmin_pkg::ST_OK),
        m_axis_tdata == stmin_pkg::SENTINEL)

    // Reset drops any pending result.
    `STMIN_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind sparse_table_range_min stmin_checker u_stmin_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
